// ===== rtl/core/kc_pkg.sv =====
// ----------------------------------------------------------------------------
// kc_pkg
// Shared types and constants of the k-combination successor block.
// ----------------------------------------------------------------------------
`default_nettype none

package kc_pkg;

    localparam int WORD_BITS     = 32;
    localparam int SET_SIZE_W    = 9;
    localparam int SUBSET_SIZE_W = 5;
    localparam int SLOT_W        = 4;
    localparam int POSITION_W    = 8;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 48;
    localparam int CFG_DATA_W    = 9;

    localparam logic [SET_SIZE_W-1:0]    RESET_SET_SIZE    = 9'd64;
    localparam logic [SUBSET_SIZE_W-1:0] RESET_SUBSET_SIZE = 5'd4;

    typedef enum logic [0:0] {
        CFG_SET_SIZE    = 1'b0,
        CFG_SUBSET_SIZE = 1'b1
    } kc_cfg_idx_t;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2
    } kc_op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_SIZE_ERR  = 2'd2
    } kc_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_CLEAR,
        ST_EMIT,
        ST_REPLAY
    } kc_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SEARCH,
        CELL_STEP
    } kc_cell_op_t;

    typedef enum logic [1:0] {
        BMP_HOLD,
        BMP_LOAD,
        BMP_CLEAR,
        BMP_SET
    } kc_bmp_op_t;

    typedef struct packed {
        kc_cell_op_t op;
        logic        sel;
        logic        first;
    } kc_cell_ctl_t;

    typedef struct packed {
        kc_bmp_op_t op;
    } kc_bmp_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/kc_cell.sv =====
// ----------------------------------------------------------------------------
// kc_cell
// One slot of the subset: holds its position, flags whether it can advance
// and refills from its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module kc_cell
    import kc_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int MAX_SET = 256
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire kc_cell_ctl_t                     ctl,
    input  wire logic [SUBSET_SIZE_W-1:0]         k,
    input  wire logic [SET_SIZE_W-1:0]            n,
    input  wire logic [$clog2(MAX_SET)-1:0]       left_pos,
    output logic      [$clog2(MAX_SET)-1:0]       pos,
    output logic      [$clog2(MAX_SET)-1:0]       next_pos,
    output logic                                  flag
);

    localparam int PW = $clog2(MAX_SET);
    localparam int CW = ((PW > SET_SIZE_W) ? PW : SET_SIZE_W) + 2;

    logic [PW-1:0] pos_reg;
    logic          flag_reg;
    logic [CW-1:0] reach;
    logic          can_step;

    assign reach    = CW'(pos_reg) + CW'(k) - CW'(IDX);
    assign can_step = (CW'(IDX) < CW'(k)) && (reach < CW'(n));
    assign next_pos = ctl.first ? pos_reg + PW'(1) : left_pos + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= PW'(IDX);
            flag_reg <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                CELL_LOAD:
                begin
                    if (CW'(IDX) < CW'(k))
                    begin
                        pos_reg <= PW'(IDX);
                    end
                end
                CELL_SEARCH:
                begin
                    flag_reg <= can_step;
                end
                CELL_STEP:
                begin
                    if (ctl.sel)
                    begin
                        pos_reg <= next_pos;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pos  = pos_reg;
    assign flag = flag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/kc_bitmap.sv =====
// ----------------------------------------------------------------------------
// kc_bitmap
// Occupancy bitmap, one bit per position, read one 32-bit word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module kc_bitmap
    import kc_pkg::*;
#(
    parameter int MAX_SET = 256
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kc_bmp_ctl_t                  ctl,
    input  wire logic [$clog2(MAX_SET)-1:0]   pos,
    input  wire logic [SUBSET_SIZE_W-1:0]     k,
    input  wire logic [2:0]                   word_index,
    output logic      [WORD_BITS-1:0]         word
);

    localparam int NW  = (MAX_SET + WORD_BITS - 1) / WORD_BITS;
    localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW  = WW + 5;
    localparam int WXW = (WW > 3) ? WW : 3;

    logic [WORD_BITS-1:0] bmp_reg [NW];
    logic [BW-1:0]        pos_ext;
    logic [WW-1:0]        pos_word;
    logic [4:0]           pos_bit;
    logic [WXW-1:0]       rd_ext;

    assign pos_ext  = BW'(pos);
    assign pos_word = pos_ext[BW-1:5];
    assign pos_bit  = pos_ext[4:0];
    assign rd_ext   = WXW'(word_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NW; w++)
            begin
                for (int b = 0; b < WORD_BITS; b++)
                begin
                    bmp_reg[w][b] <= ((w * WORD_BITS + b) < int'(RESET_SUBSET_SIZE));
                end
            end
        end
        else
        begin
            case (ctl.op)
                BMP_LOAD:
                begin
                    for (int w = 0; w < NW; w++)
                    begin
                        for (int b = 0; b < WORD_BITS; b++)
                        begin
                            bmp_reg[w][b] <= ((w * WORD_BITS + b) < int'(k));
                        end
                    end
                end
                BMP_CLEAR:
                begin
                    bmp_reg[pos_word][pos_bit] <= 1'b0;
                end
                BMP_SET:
                begin
                    bmp_reg[pos_word][pos_bit] <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign word = (int'(rd_ext) < NW) ? bmp_reg[rd_ext[WW-1:0]] : '0;

endmodule

`default_nettype wire

// ===== rtl/core/k_combination_successor.sv =====
// ----------------------------------------------------------------------------
// k_combination_successor
// Steps a sorted k-subset of n positions to its lexicographic successor and
// keeps a matching occupancy bitmap.
// Channels: s_axis carries commands (tuser opcode, tdata word index),
// m_axis carries results (tdata slot/position/bitmap word, tuser status,
// tlast on the final result of a command). cfg writes set_size (index 0)
// and subset_size (index 1); it is always ready.
// Throughput: one command at a time. A read, an error or an advance while
// exhausted is answered straight from idle; an advance with no successor
// passes the find state; a restart replays slots 0 to k - 1. An advance that
// moves slot i latches the step flags, picks the rightmost, clears the old
// bitmap bits of slots i to k - 1, then refills the cells left to right, one
// result each. The first word is registered at the edge that takes a read or
// error; otherwise it comes from the replay, find or emit state.
// The next command is taken at the earliest with the last word.
// Reset: n = 64, k = 4, slot j holds j, bitmap bits 0..3 set, not
// exhausted. A stalled receiver holds the sequencer at its next word; the
// bitmap clear pass runs on.
// ----------------------------------------------------------------------------
`default_nettype none

module k_combination_successor
    import kc_pkg::*;
#(
    parameter int MAX_SUBSET = 16,
    parameter int MAX_SET    = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]    s_axis_tdata,   // [2:0] word_index
    input  wire logic [1:0]               s_axis_tuser,   // [1:0] opcode
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [OUT_TDATA_W-1:0]   m_axis_tdata,   // [3:0] slot, [11:4] position,
                                                          // [43:12] bitmap_word
    output logic      [1:0]               m_axis_tuser,   // [1:0] status
    output logic                          m_axis_tlast,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW  = $clog2(MAX_SET);
    localparam int SW  = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
    localparam int CXW = ((SW + 1) > SUBSET_SIZE_W) ? (SW + 1) : SUBSET_SIZE_W;
    localparam int PXW = (PW > POSITION_W) ? PW : POSITION_W;
    localparam int SXW = (SW > SLOT_W) ? SW : SLOT_W;

    kc_state_t                 state_reg, state_next;
    logic [SW-1:0]             cursor_reg, cursor_next;
    logic [SW-1:0]             start_reg, start_next;
    logic                      exhausted_reg, exhausted_next;
    logic [SET_SIZE_W-1:0]     set_size_reg;
    logic [SUBSET_SIZE_W-1:0]  subset_size_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic [POSITION_W-1:0]     out_pos_reg, out_pos_next;
    logic [WORD_BITS-1:0]      out_word_reg, out_word_next;
    kc_status_t                out_status_reg, out_status_next;
    logic                      out_last_reg, out_last_next;

    kc_cell_op_t               cell_op;
    kc_bmp_ctl_t               bmp_ctl;
    logic [PW-1:0]             bmp_pos;
    logic [WORD_BITS-1:0]      bmp_word;

    logic [PW-1:0]             cell_pos  [MAX_SUBSET];
    logic [PW-1:0]             cell_next [MAX_SUBSET];
    logic [MAX_SUBSET-1:0]     cell_flag;

    logic                      any_flag;
    logic [SW-1:0]             find_idx;
    logic                      out_free;
    logic                      in_take;
    logic                      size_err;
    logic                      emit_last;
    logic [PW-1:0]             cur_pos;
    logic [PW-1:0]             cur_next;
    logic [PXW-1:0]            cur_pos_w;
    logic [PXW-1:0]            cur_next_w;
    logic [SXW-1:0]            slot_w;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= RESET_SET_SIZE;
            subset_size_reg <= RESET_SUBSET_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (kc_cfg_idx_t'(cfg_index))
                CFG_SET_SIZE:    set_size_reg    <= cfg_data[SET_SIZE_W-1:0];
                CFG_SUBSET_SIZE: subset_size_reg <= cfg_data[SUBSET_SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // row of slot cells
    for (genvar g = 0; g < MAX_SUBSET; g++)
    begin : g_cell
        kc_cell_ctl_t  ctl;
        logic [PW-1:0] left;

        assign ctl.op    = cell_op;
        assign ctl.sel   = (cursor_reg == SW'(g));
        assign ctl.first = (cursor_reg == start_reg);

        if (g == 0)
        begin : g_head
            assign left = '0;
        end
        else
        begin : g_link
            assign left = cell_pos[g-1];
        end

        kc_cell #(
            .IDX     (g),
            .MAX_SET (MAX_SET)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .k        (subset_size_reg),
            .n        (set_size_reg),
            .left_pos (left),
            .pos      (cell_pos[g]),
            .next_pos (cell_next[g]),
            .flag     (cell_flag[g])
        );
    end

    kc_bitmap #(
        .MAX_SET (MAX_SET)
    ) u_bitmap (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (bmp_ctl),
        .pos        (bmp_pos),
        .k          (subset_size_reg),
        .word_index (s_axis_tdata[2:0]),
        .word       (bmp_word)
    );

    // rightmost slot that can step
    always_comb
    begin
        any_flag = 1'b0;
        find_idx = '0;
        for (int j = 0; j < MAX_SUBSET; j++)
        begin
            if (cell_flag[j])
            begin
                any_flag = 1'b1;
                find_idx = SW'(j);
            end
        end
    end

    assign size_err = (subset_size_reg == '0)
                   || (int'(subset_size_reg) > MAX_SUBSET)
                   || (int'(set_size_reg) > MAX_SET)
                   || (SET_SIZE_W'(subset_size_reg) > set_size_reg);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign cur_pos    = cell_pos[cursor_reg];
    assign cur_next   = cell_next[cursor_reg];
    assign cur_pos_w  = PXW'(cur_pos);
    assign cur_next_w = PXW'(cur_next);
    assign slot_w     = SXW'(cursor_reg);
    assign emit_last  = (CXW'(cursor_reg) + CXW'(1)) == CXW'(subset_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            start_reg     <= '0;
            exhausted_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            start_reg     <= start_next;
            exhausted_reg <= exhausted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg   <= out_slot_next;
        out_pos_reg    <= out_pos_next;
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        start_next      = start_reg;
        exhausted_next  = exhausted_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_slot_next   = out_slot_reg;
        out_pos_next    = out_pos_reg;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        cell_op         = CELL_HOLD;
        bmp_ctl.op      = BMP_HOLD;
        bmp_pos         = cur_pos;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (kc_op_t'(s_axis_tuser))
                        OP_RESTART:
                        begin
                            if (size_err)
                            begin
                                out_valid_next  = 1'b1;
                                out_slot_next   = '0;
                                out_pos_next    = '0;
                                out_word_next   = '0;
                                out_status_next = STAT_SIZE_ERR;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                cell_op        = CELL_LOAD;
                                bmp_ctl.op     = BMP_LOAD;
                                exhausted_next = 1'b0;
                                cursor_next    = '0;
                                state_next     = ST_REPLAY;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            if (size_err || exhausted_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_slot_next   = '0;
                                out_pos_next    = '0;
                                out_word_next   = '0;
                                out_status_next = size_err ? STAT_SIZE_ERR : STAT_EXHAUSTED;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                cell_op    = CELL_SEARCH;
                                state_next = ST_FIND;
                            end
                        end
                        OP_READ:
                        begin
                            out_valid_next  = 1'b1;
                            out_slot_next   = '0;
                            out_pos_next    = '0;
                            out_word_next   = bmp_word;
                            out_status_next = STAT_OK;
                            out_last_next   = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                if (any_flag)
                begin
                    start_next  = find_idx;
                    cursor_next = find_idx;
                    state_next  = ST_CLEAR;
                end
                else if (out_free)
                begin
                    exhausted_next  = 1'b1;
                    out_valid_next  = 1'b1;
                    out_slot_next   = '0;
                    out_pos_next    = '0;
                    out_word_next   = '0;
                    out_status_next = STAT_EXHAUSTED;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                bmp_ctl.op = BMP_CLEAR;
                bmp_pos    = cur_pos;
                if (emit_last)
                begin
                    cursor_next = start_reg;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    cursor_next = cursor_reg + SW'(1);
                end
            end
            ST_EMIT:
            begin
                bmp_pos = cur_next;
                if (out_free)
                begin
                    cell_op         = CELL_STEP;
                    bmp_ctl.op      = BMP_SET;
                    out_valid_next  = 1'b1;
                    out_slot_next   = slot_w[SLOT_W-1:0];
                    out_pos_next    = cur_next_w[POSITION_W-1:0];
                    out_word_next   = '0;
                    out_status_next = STAT_OK;
                    out_last_next   = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + SW'(1);
                    end
                end
            end
            ST_REPLAY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = slot_w[SLOT_W-1:0];
                    out_pos_next    = cur_pos_w[POSITION_W-1:0];
                    out_word_next   = '0;
                    out_status_next = STAT_OK;
                    out_last_next   = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + SW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_word_reg, out_pos_reg, out_slot_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    a_exhaust_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(exhausted_reg) |-> $past(state_reg) == ST_FIND)
        else $error("exhausted set outside the search");

    a_emit_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && emit_last) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after last slot");

    a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> cursor_reg >= start_reg)
        else $error("clear cursor left of the stepped slot");

    a_emit_not_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !exhausted_reg)
        else $error("refill running while exhausted");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> m_axis_tlast)
        else $error("error status word not marked last");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-combination successor. Commands are driven
// from a queue, every accepted command is run through a bench-side model of
// the subset and its occupancy bitmap, and every result word is checked in
// order against the predicted slot, position, bitmap word, status and last
// flag. Phases step through several set and subset sizes with varying idle
// and stall rates on both streams, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import kc_pkg::*;

    localparam int MAX_SUBSET     = 16;
    localparam int MAX_SET        = 256;
    localparam int NUM_WORDS      = MAX_SET / WORD_BITS;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] widx;
    } command_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [POSITION_W-1:0] position;
        logic [WORD_BITS-1:0]  bitmap_word;
        kc_status_t            status;
        logic                  last;
    } slot_report_t;

    logic                     clk;
    logic                     rst_n          = 1'b0;
    logic                     s_axis_tvalid  = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata   = '0;   // [2:0] word_index
    logic [1:0]               s_axis_tuser   = '0;   // [1:0] opcode
    logic                     m_axis_tvalid;
    logic                     m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;          // [3:0] slot, [11:4] position,
                                                     // [43:12] bitmap_word
    logic [1:0]               m_axis_tuser;          // [1:0] status
    logic                     m_axis_tlast;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    kc_cfg_idx_t              cfg_index      = CFG_SET_SIZE;
    logic [CFG_DATA_W-1:0]    cfg_data       = '0;

    command_word_t pending_commands[$];
    slot_report_t  pending_reports[$];

    int cmds_sent          = 0;
    int cmds_taken         = 0;
    int cfg_writes_done    = 0;
    int mismatch_count     = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served        = 0;
    int hold_left          = 0;

    // model of the subset, bitmap and registers
    logic [8:0]           model_set_size;
    logic [4:0]           model_subset_size;
    logic [7:0]           model_pos [MAX_SUBSET];
    logic [WORD_BITS-1:0] model_occ [NUM_WORDS];
    logic                 model_exhausted;

    k_combination_successor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("k_combination_successor verification failed");
        $finish;
    end

    task automatic push_report(int slot, int position, logic [31:0] word,
                               kc_status_t status, logic last);
        slot_report_t r;
        r.slot        = slot[SLOT_W-1:0];
        r.position    = position[POSITION_W-1:0];
        r.bitmap_word = word;
        r.status      = status;
        r.last        = last;
        pending_reports.push_back(r);
    endtask

    task automatic mark_position(int p, logic on);
        if ((p / WORD_BITS) < NUM_WORDS)
            model_occ[p / WORD_BITS][p % WORD_BITS] = on;
    endtask

    task automatic predict_combination_step(logic [1:0] op, logic [2:0] widx);
        int  n;
        int  k;
        int  j;
        int  pivot;
        bit  found;
        n     = model_set_size;
        k     = model_subset_size;
        pivot = 0;
        found = 1'b0;
        if (op == OP_READ)
            push_report(0, 0, model_occ[widx], STAT_OK, 1'b1);
        else if (op != OP_UNUSED)
        begin
            if (k == 0 || k > MAX_SUBSET || n > MAX_SET || k > n)
                push_report(0, 0, '0, STAT_SIZE_ERR, 1'b1);
            else if (op == OP_RESTART)
            begin
                for (j = 0; j < NUM_WORDS; j++)
                    model_occ[j] = '0;
                for (j = 0; j < k; j++)
                begin
                    model_pos[j] = j[7:0];
                    mark_position(j, 1'b1);
                    push_report(j, j, '0, STAT_OK, j == k - 1);
                end
                model_exhausted = 1'b0;
            end
            else
            begin
                if (!model_exhausted)
                begin
                    for (j = k - 1; j >= 0; j--)
                    begin
                        if (int'(model_pos[j]) + 1 < n - (k - 1 - j))
                        begin
                            pivot = j;
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (!found)
                begin
                    model_exhausted = 1'b1;
                    push_report(0, 0, '0, STAT_EXHAUSTED, 1'b1);
                end
                else
                begin
                    for (j = pivot; j < k; j++)
                        mark_position(model_pos[j], 1'b0);
                    model_pos[pivot] = model_pos[pivot] + 8'd1;
                    for (j = pivot + 1; j < k; j++)
                        model_pos[j] = model_pos[j - 1] + 8'd1;
                    for (j = pivot; j < k; j++)
                    begin
                        mark_position(model_pos[j], 1'b1);
                        push_report(j, model_pos[j], '0, STAT_OK, j == k - 1);
                    end
                end
            end
        end
    endtask

    // input, config and output tracking
    always @(posedge clk or negedge rst_n)
    begin : track_traffic
        slot_report_t want;
        slot_report_t seen;
        if (!rst_n)
        begin
            model_set_size    = RESET_SET_SIZE;
            model_subset_size = RESET_SUBSET_SIZE;
            for (int j = 0; j < MAX_SUBSET; j++)
                model_pos[j] = j[7:0];
            for (int j = 0; j < NUM_WORDS; j++)
                model_occ[j] = '0;
            for (int j = 0; j < RESET_SUBSET_SIZE; j++)
                mark_position(j, 1'b1);
            model_exhausted = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.slot        = m_axis_tdata[3:0];
                seen.position    = m_axis_tdata[11:4];
                seen.bitmap_word = m_axis_tdata[43:12];
                seen.status      = kc_status_t'(m_axis_tuser);
                seen.last        = m_axis_tlast;
                if (pending_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: slot %0d pos %0d word %h status %0d last %0b",
                                 seen.slot, seen.position, seen.bitmap_word,
                                 seen.status, seen.last);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected slot %0d pos %0d word %h status %0d",
                                      " last %0b, got slot %0d pos %0d word %h status %0d",
                                      " last %0b"},
                                     want.slot, want.position, want.bitmap_word,
                                     want.status, want.last, seen.slot, seen.position,
                                     seen.bitmap_word, seen.status, seen.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SET_SIZE:    model_set_size    = cfg_data;
                    CFG_SUBSET_SIZE: model_subset_size = cfg_data[4:0];
                    default: ;
                endcase
                cfg_writes_done++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_combination_step(s_axis_tuser, s_axis_tdata[2:0]);
                cmds_taken++;
            end
        end
    end

    always @(negedge clk)
    begin : drive_commands
        command_word_t next_cmd;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!(s_axis_tvalid && cmds_taken != cmds_sent))
        begin
            if (pending_commands.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_cmd = pending_commands.pop_front();
                s_axis_tuser  <= next_cmd.op;
                s_axis_tdata  <= {{(IN_TDATA_W-3){1'b0}}, next_cmd.widx};
                s_axis_tvalid <= 1'b1;
                cmds_sent++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic queue_command(logic [1:0] op, logic [2:0] widx);
        command_word_t c;
        c.op   = op;
        c.widx = widx;
        pending_commands.push_back(c);
    endtask

    task automatic write_reg(kc_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        int target;
        target = cfg_writes_done + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk);
        while (cfg_writes_done < target);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_commands.size() != 0 || cmds_taken != cmds_sent ||
               pending_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int         phase;
        int         queued;
        int         r;
        int         n_sel;
        int         k_sel;
        logic [1:0] op;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset state, ignored opcode
        queue_command(OP_READ, 3'd0);
        queue_command(OP_READ, 3'd7);
        queue_command(OP_ADVANCE, 3'd5);
        queue_command(OP_ADVANCE, 3'd2);
        queue_command(OP_UNUSED, 3'd7);
        queue_command(OP_READ, 3'd0);
        queue_command(OP_RESTART, 3'd0);
        wait_drained();

        // run to the end of all subsets, then sticky exhaustion
        write_reg(CFG_SET_SIZE, 9'd4);
        write_reg(CFG_SUBSET_SIZE, 9'd3);
        queue_command(OP_RESTART, 3'd0);
        repeat (5) queue_command(OP_ADVANCE, 3'd0);
        queue_command(OP_READ, 3'd0);
        wait_drained();

        // subset larger than set
        write_reg(CFG_SUBSET_SIZE, 9'd5);
        queue_command(OP_ADVANCE, 3'd0);
        queue_command(OP_RESTART, 3'd0);
        wait_drained();

        // largest sizes, first advance on the held positions
        write_reg(CFG_SET_SIZE, 9'd256);
        write_reg(CFG_SUBSET_SIZE, 9'd16);
        queue_command(OP_ADVANCE, 3'd0);
        queue_command(OP_READ, 3'd7);
        queue_command(OP_RESTART, 3'd0);
        queue_command(OP_ADVANCE, 3'd0);
        wait_drained();

        write_reg(CFG_SET_SIZE, 9'd1);
        write_reg(CFG_SUBSET_SIZE, 9'd1);
        queue_command(OP_RESTART, 3'd0);
        queue_command(OP_ADVANCE, 3'd0);
        wait_drained();

        write_reg(CFG_SUBSET_SIZE, 9'd0);
        queue_command(OP_ADVANCE, 3'd0);
        wait_drained();
        write_reg(CFG_SUBSET_SIZE, 9'd31);
        queue_command(OP_RESTART, 3'd0);
        wait_drained();
        write_reg(CFG_SET_SIZE, 9'd511);
        write_reg(CFG_SUBSET_SIZE, 9'd4);
        queue_command(OP_ADVANCE, 3'd0);
        wait_drained();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase / 2)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
            endcase
            r = $urandom_range(9);
            if (r < 6)
            begin
                n_sel = $urandom_range(1, 10);
                k_sel = $urandom_range(1, n_sel);
            end
            else if (r < 8)
            begin
                n_sel = $urandom_range(17, 256);
                k_sel = $urandom_range(1, 16);
            end
            else if (r == 8)
            begin
                n_sel = 256;
                k_sel = 16;
            end
            else
            begin
                n_sel = $urandom_range(1, 15);
                k_sel = n_sel + 1;
            end
            write_reg(CFG_SET_SIZE, n_sel[8:0]);
            write_reg(CFG_SUBSET_SIZE, k_sel[8:0]);
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 58)
                    op = OP_ADVANCE;
                else if (r < 70)
                    op = OP_RESTART;
                else if (r < 94)
                    op = OP_READ;
                else
                    op = OP_UNUSED;
                queue_command(op, $urandom_range(7));
                if (op != OP_UNUSED)
                    queued++;
            end
            wait_drained();
        end

        // long receiver hold-off while commands keep coming
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_reg(CFG_SET_SIZE, 9'd20);
        write_reg(CFG_SUBSET_SIZE, 9'd16);
        hold_requests++;
        for (r = 0; r < 12; r++)
            queue_command((r % 4 == 0) ? OP_RESTART : OP_ADVANCE, $urandom_range(7));
        queue_command(OP_READ, 3'd0);
        wait_drained();

        if (mismatch_count == 0)
            $display("k_combination_successor verification clean");
        else
            $display("k_combination_successor verification failed");
        $finish;
    end

endmodule
